// File: rtl/core/texture_cache_tag_table_macros.svh
// Assertion macros for the texture cache tag table.
`ifndef TEXTURE_CACHE_TAG_TABLE_MACROS_SVH
`define TEXTURE_CACHE_TAG_TABLE_MACROS_SVH
// Assert a property under the block reset.
`define TCT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Assert that a condition never holds.
`define TCT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`endif

// File: rtl/core/tct_pkg.sv
// Package with types and constants of the texture cache tag table.
package tct_pkg;
  localparam int unsigned SlotsPerPage = 32;
  localparam int unsigned PagesAcross = 16;
  localparam int unsigned PageRows = 2;
  localparam int unsigned PageWidth = 64;
  localparam int unsigned PageHeight = 256;
  localparam int unsigned TotalPages = PagesAcross * PageRows;
  localparam int unsigned TotalSlots = TotalPages * SlotsPerPage;
  localparam int unsigned AddrW = $clog2(TotalSlots);
  localparam int unsigned SlotW = $clog2(SlotsPerPage);
  localparam int unsigned PageW = $clog2(TotalPages);

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0, OP_FIND = 2'd1, OP_INVAL = 2'd2, OP_NOP = 2'd3
  } opcode_e;

  localparam logic [1:0] ST_FREE = 2'd0;
  localparam logic [1:0] ST_BUILT = 2'd1;
  localparam logic [1:0] ST_STALE = 2'd2;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  cmode;
    logic [15:0] palette;
    logic [31:0] generation;
    logic [63:0] key;
  } slot_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_FREAD, S_FCHK, S_PAGE, S_OREAD, S_OCHK,
    S_LREAD, S_LCHK, S_SREAD, S_SCHK, S_DONE
  } state_e;

  // Fields from the highest bit down, so found_slot lands in the low bits.
  typedef struct packed {
    logic [10:0] staled_count;
    logic [10:0] closed_up_count;
    logic [10:0] dropped_count;
    logic        marked_stale;
    logic [5:0]  found_slot;
  } result_t;
endpackage

// File: rtl/core/texture_cache_tag_table.sv
// Top level of the texture cache tag table.
// Usage: one input beat on s_axis (opcode, page, slot, entry fields, key and
// dirty rectangle) gives exactly one result beat on m_axis.
// The table lives in one single-port memory of 1024 slots with a registered
// read; one item is worked at a time by a sequencer.
// A write goes straight to the result. Find reads and checks one slot at a
// time, up to all 32 slots of the page. Invalidate visits all 32 pages; a hit
// page has its own list walked slot by slot, and the left page close-up
// shifts the later slots down for each removed entry; the memory port sets
// the pace of all these steps.
// After reset a clearing pass writes every slot to zero, during which
// s_axis_tready is low.
// The result sits in an output register; while the receiver stalls the block
// holds it and takes no new item until it is taken.
module texture_cache_tag_table
  import tct_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // opcode[1:0] page[6:2] slot[11:7] entry_state[13:12] mode[21:14]
  // palette[38:22] generation[70:39] key[134:71] rect_x[150:135]
  // rect_y[166:151] rect_w[182:167] rect_h[198:183], zero fill to 200
  input  logic [199:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // found_slot[5:0] marked_stale[6] dropped_count[17:7]
  // closed_up_count[28:18] staled_count[39:29]
  output logic [39:0]  m_axis_tdata
);
  `include "texture_cache_tag_table_macros.svh"

  slot_t mem_q [TotalSlots];
  slot_t rd_q;
  logic we;
  logic [AddrW-1:0] waddr, raddr;
  slot_t wdata;
  logic re;

  // Memory: write and registered read.
  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (re) rd_q <= mem_q[raddr];
  end

  state_e state_q, state_d;
  logic [199:0] in_q, in_d;
  logic [AddrW:0] clr_q, clr_d;
  logic [SlotW:0] i_q, i_d, k_q, k_d;
  logic [PageW:0] pg_q, pg_d;
  result_t res_q, res_d;
  logic out_v_q, out_v_d;

  // Unpack the held item.
  logic [4:0] ipage;
  logic [7:0] imode;
  logic [16:0] ipal;
  logic [31:0] igen;
  logic [63:0] ikey;
  logic signed [17:0] dl, dt, dr, db;
  assign ipage = in_q[6:2];
  assign imode = in_q[21:14];
  assign ipal = in_q[38:22];
  assign igen = in_q[70:39];
  assign ikey = in_q[134:71];
  assign dl = 18'(signed'(in_q[150:135]));
  assign dt = 18'(signed'(in_q[166:151]));
  assign dr = dl + 18'(signed'(in_q[182:167])) - 18'sd1;
  assign db = dt + 18'(signed'(in_q[198:183])) - 18'sd1;

  // Page rectangle of the current page.
  logic [PageW-1:0] pidx;
  logic [3:0] pcol;
  logic signed [17:0] pl, pt, pr, pb, mxl, mnr, mxt, mnb;
  logic phit, drop;
  assign pidx = pg_q[PageW-1:0];
  assign pcol = pidx[3:0];
  assign pl = 18'(pcol) * 18'(PageWidth);
  assign pt = 18'(pidx[PageW-1:4]) * 18'(PageHeight);
  assign pr = pl + 18'(PageWidth - 1);
  assign pb = pt + 18'(PageHeight - 1);
  assign mxl = (pl > dl) ? pl : dl;
  assign mnr = (pr < dr) ? pr : dr;
  assign mxt = (pt > dt) ? pt : dt;
  assign mnb = (pb < db) ? pb : db;
  assign phit = (mxl < mnr) && (mxt < mnb);
  assign drop = (imode == 8'd0);

  logic [PageW-1:0] lpage;
  assign lpage = pidx - PageW'(1);
  logic [SlotW-1:0] ii, kk;
  assign ii = i_q[SlotW-1:0];
  assign kk = k_q[SlotW-1:0];

  assign s_axis_tready = (state_q == S_IDLE) && !out_v_q;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = res_q;

  // Sequencer: next state, memory access and counts.
  always_comb begin
    state_d = state_q; in_d = in_q; clr_d = clr_q; i_d = i_q; k_d = k_q;
    pg_d = pg_q; res_d = res_q; out_v_d = out_v_q;
    we = 1'b0; waddr = '0; wdata = '0; re = 1'b0; raddr = '0;
    if (out_v_q && m_axis_tready) out_v_d = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        we = 1'b1; waddr = clr_q[AddrW-1:0];
        clr_d = clr_q + 1'b1;
        if (clr_q == (AddrW+1)'(TotalSlots - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          in_d = s_axis_tdata; res_d = '0; i_d = '0; pg_d = '0;
          unique case (opcode_e'(s_axis_tdata[1:0]))
            OP_WRITE: begin
              we = 1'b1;
              waddr = {s_axis_tdata[6:2], s_axis_tdata[11:7]};
              wdata.status = s_axis_tdata[13:12];
              wdata.cmode = s_axis_tdata[21:14];
              wdata.palette = s_axis_tdata[37:22];
              wdata.generation = s_axis_tdata[70:39];
              wdata.key = s_axis_tdata[134:71];
              state_d = S_DONE;
            end
            OP_FIND: begin
              res_d.found_slot = 6'(SlotsPerPage);
              state_d = S_FREAD;
            end
            OP_INVAL: state_d = S_PAGE;
            default: state_d = S_DONE;
          endcase
        end
      end
      S_FREAD: begin
        re = 1'b1; raddr = {ipage, ii}; state_d = S_FCHK;
      end
      S_FCHK: begin
        state_d = S_FREAD; i_d = i_q + 1'b1;
        if (rd_q.status == ST_FREE) state_d = S_DONE;
        else if (rd_q.key == ikey) begin
          if (imode[1]) begin
            if (rd_q.cmode == 8'd2) begin
              res_d.found_slot = 6'(ii); state_d = S_DONE;
            end
          end else if ({1'b0, rd_q.palette} == ipal) begin
            res_d.found_slot = 6'(ii); state_d = S_DONE;
            if (rd_q.generation != igen) begin
              res_d.marked_stale = 1'b1;
              we = 1'b1; waddr = {ipage, ii};
              wdata = rd_q; wdata.status = ST_STALE;
            end
          end
        end
        if (state_d == S_FREAD && i_q == (SlotW+1)'(SlotsPerPage - 1)) state_d = S_DONE;
      end
      S_PAGE: begin
        i_d = '0;
        if (pg_q == (PageW+1)'(TotalPages)) state_d = S_DONE;
        else if (phit) state_d = S_OREAD;
        else pg_d = pg_q + 1'b1;
      end
      S_OREAD: begin
        re = 1'b1; raddr = {pidx, ii}; state_d = S_OCHK;
      end
      S_OCHK: begin
        i_d = i_q + 1'b1; state_d = S_OREAD;
        if (drop) begin
          if (rd_q.status == ST_FREE) state_d = S_LREAD;
          else begin
            we = 1'b1; waddr = {pidx, ii};
            res_d.dropped_count = res_q.dropped_count + 1'b1;
          end
        end else if (rd_q.status == ST_BUILT) begin
          we = 1'b1; waddr = {pidx, ii}; wdata = rd_q; wdata.status = ST_STALE;
          res_d.staled_count = res_q.staled_count + 1'b1;
        end
        if (i_q == (SlotW+1)'(SlotsPerPage - 1)) state_d = S_LREAD;
        if (state_d == S_LREAD) begin
          i_d = '0;
          if (pcol == 4'd0) begin state_d = S_PAGE; pg_d = pg_q + 1'b1; end
        end
      end
      S_LREAD: begin
        if (i_q == (SlotW+1)'(SlotsPerPage)) begin
          state_d = S_PAGE; pg_d = pg_q + 1'b1;
        end else begin
          re = 1'b1; raddr = {lpage, ii}; state_d = S_LCHK;
        end
      end
      S_LCHK: begin
        state_d = S_LREAD;
        if (!drop) begin
          i_d = i_q + 1'b1;
          if (rd_q.status == ST_BUILT && rd_q.cmode != 8'd0) begin
            we = 1'b1; waddr = {lpage, ii}; wdata = rd_q; wdata.status = ST_STALE;
            res_d.staled_count = res_q.staled_count + 1'b1;
          end
        end else if (rd_q.status == ST_FREE) begin
          state_d = S_PAGE; pg_d = pg_q + 1'b1;
        end else if (rd_q.cmode == 8'd0) i_d = i_q + 1'b1;
        else begin
          res_d.closed_up_count = res_q.closed_up_count + 1'b1;
          k_d = i_q; state_d = S_SREAD;
        end
      end
      S_SREAD: begin
        // Shift one slot down; clear the last.
        if (k_q == (SlotW+1)'(SlotsPerPage - 1)) begin
          we = 1'b1; waddr = {lpage, kk}; state_d = S_LREAD;
        end else begin
          re = 1'b1; raddr = {lpage, SlotW'(k_q + 1'b1)}; state_d = S_SCHK;
        end
      end
      S_SCHK: begin
        we = 1'b1; waddr = {lpage, kk}; wdata = rd_q;
        k_d = k_q + 1'b1; state_d = S_SREAD;
      end
      S_DONE: begin
        if (!out_v_q) begin out_v_d = 1'b1; state_d = S_IDLE; end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; clr_q <= '0; out_v_q <= 1'b0;
      i_q <= '0; k_q <= '0; pg_q <= '0;
    end else begin
      state_q <= state_d; clr_q <= clr_d; out_v_q <= out_v_d;
      i_q <= i_d; k_q <= k_d; pg_q <= pg_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    in_q <= in_d; res_q <= res_d;
  end

  `TCT_NEVER(a_no_take_busy, s_axis_tready && state_q != S_IDLE, "ready while busy")
  `TCT_ASSERT(a_hold_res, out_v_q && !m_axis_tready |=> $stable(res_q), "result changed")
  `TCT_NEVER(a_found_range, out_v_q && res_q.found_slot > 6'(SlotsPerPage), "bad slot")
endmodule

// File: tb/texture_cache_tag_table_tb.sv
// Stream testbench for the texture cache tag table, with its own tag-table predictor.
`timescale 1ns / 100ps

module texture_cache_tag_table_tb;
  import tct_pkg::*;

  typedef struct {
    opcode_e     op;
    logic [4:0]  page;
    logic [4:0]  slot;
    logic [1:0]  entry_state;
    logic [7:0]  mode;
    logic [16:0] palette;
    logic [31:0] generation;
    logic [63:0] key;
    logic [15:0] rect_x, rect_y, rect_w, rect_h;
  } tag_req_t;

  typedef struct {
    logic [5:0]  found_slot;
    logic        marked_stale;
    logic [10:0] dropped_count;
    logic [10:0] closed_up_count;
    logic [10:0] staled_count;
  } tag_resp_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [199:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [39:0]  m_axis_tdata;

  // Shadow copy of the tag table.
  logic [1:0]  tbl_status [TotalSlots];
  logic [7:0]  tbl_cmode [TotalSlots];
  logic [15:0] tbl_palette [TotalSlots];
  logic [31:0] tbl_gen [TotalSlots];
  logic [63:0] tbl_key [TotalSlots];

  tag_req_t  pending_reqs[$];
  tag_resp_t expected_results[$];
  tag_req_t  cur_req;
  int        req_gap;
  int        hold_cycles;
  int        beats_out;
  int        fail_count;
  bit        burst_mode;

  texture_cache_tag_table DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [199:0] pack_req(tag_req_t r);
    return {1'b0, r.rect_h, r.rect_w, r.rect_y, r.rect_x, r.key, r.generation,
            r.palette, r.mode, r.entry_state, r.slot, r.page, r.op};
  endfunction

  function automatic void clear_entry(int n);
    tbl_status[n] = ST_FREE;
    tbl_cmode[n] = '0;
    tbl_palette[n] = '0;
    tbl_gen[n] = '0;
    tbl_key[n] = '0;
  endfunction

  // Apply one request to the shadow table and return the result it should give.
  function automatic tag_resp_t tag_table_predict(tag_req_t r);
    tag_resp_t res;
    int base, lft, n, i, k, pl, pt, pr, pb, dl, dt, dr, db;
    int dropped, closed, staled;
    bit drop;
    res = '{default: '0};
    dropped = 0;
    closed = 0;
    staled = 0;
    case (r.op)
      OP_WRITE: begin
        n = r.page * SlotsPerPage + r.slot;
        tbl_status[n] = r.entry_state;
        tbl_cmode[n] = r.mode;
        tbl_palette[n] = r.palette[15:0];
        tbl_gen[n] = r.generation;
        tbl_key[n] = r.key;
      end
      OP_FIND: begin
        res.found_slot = 6'(SlotsPerPage);
        for (i = 0; i < SlotsPerPage; i++) begin
          n = r.page * SlotsPerPage + i;
          if (tbl_status[n] == ST_FREE) break;
          if (tbl_key[n] != r.key) continue;
          if (r.mode[1]) begin
            if (tbl_cmode[n] == 8'd2) begin
              res.found_slot = 6'(i);
              break;
            end
            continue;
          end
          if ({1'b0, tbl_palette[n]} != r.palette) continue;
          if (tbl_gen[n] != r.generation) begin
            tbl_status[n] = ST_STALE;
            res.marked_stale = 1'b1;
          end
          res.found_slot = 6'(i);
          break;
        end
      end
      OP_INVAL: begin
        dl = $signed(r.rect_x);
        dt = $signed(r.rect_y);
        dr = dl + $signed(r.rect_w) - 1;
        db = dt + $signed(r.rect_h) - 1;
        drop = (r.mode == 8'd0);
        for (int pg = 0; pg < TotalPages; pg++) begin
          pl = (pg % PagesAcross) * PageWidth;
          pt = (pg / PagesAcross) * PageHeight;
          pr = pl + PageWidth - 1;
          pb = pt + PageHeight - 1;
          // Edges compare as exclusive although they are inclusive.
          if (!(((pl > dl) ? pl : dl) < ((pr < dr) ? pr : dr) &&
                ((pt > dt) ? pt : dt) < ((pb < db) ? pb : db))) continue;
          base = pg * SlotsPerPage;
          for (i = 0; i < SlotsPerPage; i++) begin
            n = base + i;
            if (!drop) begin
              if (tbl_status[n] == ST_BUILT) begin
                tbl_status[n] = ST_STALE;
                staled++;
              end
              continue;
            end
            if (tbl_status[n] == ST_FREE) break;
            clear_entry(n);
            dropped++;
          end
          if (pg % PagesAcross == 0) continue;
          // Close up the wide entries of the page to the left; without drop, mark them stale.
          lft = base - SlotsPerPage;
          i = 0;
          while (i < SlotsPerPage) begin
            n = lft + i;
            if (!drop) begin
              if (tbl_status[n] == ST_BUILT && tbl_cmode[n] != 0) begin
                tbl_status[n] = ST_STALE;
                staled++;
              end
              i++;
              continue;
            end
            if (tbl_status[n] == ST_FREE) break;
            if (tbl_cmode[n] == 0) begin
              i++;
              continue;
            end
            for (k = i; k < SlotsPerPage - 1; k++) begin
              tbl_status[lft + k] = tbl_status[lft + k + 1];
              tbl_cmode[lft + k] = tbl_cmode[lft + k + 1];
              tbl_palette[lft + k] = tbl_palette[lft + k + 1];
              tbl_gen[lft + k] = tbl_gen[lft + k + 1];
              tbl_key[lft + k] = tbl_key[lft + k + 1];
            end
            clear_entry(lft + SlotsPerPage - 1);
            closed++;
          end
        end
        res.dropped_count = dropped[10:0];
        res.closed_up_count = closed[10:0];
        res.staled_count = staled[10:0];
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic tag_req_t mk_req(opcode_e op, int page, int slot, int st, int mode,
                                      int pal, logic [31:0] gen, logic [63:0] key);
    tag_req_t r;
    r.op = op;
    r.page = 5'(page);
    r.slot = 5'(slot);
    r.entry_state = 2'(st);
    r.mode = 8'(mode);
    r.palette = 17'(pal);
    r.generation = gen;
    r.key = key;
    r.rect_x = 16'($urandom);
    r.rect_y = 16'($urandom);
    r.rect_w = 16'($urandom);
    r.rect_h = 16'($urandom);
    return r;
  endfunction

  function automatic tag_req_t mk_inval(int mode, int x, int y, int w, int h);
    tag_req_t r;
    r = mk_req(OP_INVAL, $urandom, $urandom, $urandom, mode, $urandom, $urandom,
               {$urandom, $urandom});
    r.rect_x = 16'(x);
    r.rect_y = 16'(y);
    r.rect_w = 16'(w);
    r.rect_h = 16'(h);
    return r;
  endfunction

  // Random request: mostly page lists built from slot 0 with a small key pool.
  function automatic tag_req_t rand_req();
    tag_req_t r;
    logic [63:0] key_pool [4] = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF,
                                  64'h1234_5678_9ABC_DEF0, 64'h8000_0000_0000_0001};
    int sel;
    logic [63:0] k;
    sel = $urandom_range(0, 99);
    k = ($urandom_range(0, 4) == 0) ? {$urandom, $urandom} : key_pool[$urandom_range(0, 3)];
    r = mk_req(OP_WRITE, $urandom_range(0, 3) == 0 ? $urandom_range(0, 31)
                                                   : $urandom_range(0, 5),
               $urandom_range(0, 5) == 0 ? $urandom_range(0, 31) : $urandom_range(0, 6),
               $urandom_range(0, 5) == 0 ? $urandom_range(0, 3) : 1,
               $urandom_range(0, 2) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 2),
               $urandom_range(0, 5) == 0 ? $urandom_range(0, 131071) : $urandom_range(0, 3),
               $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 1), k);
    if (sel < 45) return r;
    if (sel < 80) begin
      r.op = OP_FIND;
      r.page = 5'($urandom_range(0, 3) == 0 ? $urandom_range(0, 31) : $urandom_range(0, 5));
      return r;
    end
    if (sel < 95) begin
      r.op = OP_INVAL;
      r.mode = $urandom_range(0, 1) ? 8'd0 : r.mode;
      if ($urandom_range(0, 4) != 0) begin
        r.rect_x = 16'($urandom_range(0, 1200) - 100);
        r.rect_y = 16'($urandom_range(0, 700) - 100);
        r.rect_w = 16'($urandom_range(0, 200) - 20);
        r.rect_h = 16'($urandom_range(0, 300) - 20);
      end
      return r;
    end
    r.op = OP_NOP;
    return r;
  endfunction

  // Feed request beats with random gaps and stretches of back-to-back beats.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) expected_results.push_back(tag_table_predict(cur_req));
      if (req_gap > 0) begin
        req_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        cur_req = pending_reqs.pop_front();
        s_axis_tdata <= pack_req(cur_req);
        s_axis_tvalid <= 1'b1;
        if ($urandom_range(0, 31) == 0) burst_mode = !burst_mode;
        req_gap = burst_mode ? 0 : $urandom_range(0, 15);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Check result beats and stall the output side, once for a long stretch.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        beats_out++;
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: %h", m_axis_tdata);
          fail_count++;
        end else begin
          tag_resp_t e;
          e = expected_results.pop_front();
          if (m_axis_tdata[5:0] !== e.found_slot) begin
            $error("found_slot exp %0d got %0d", e.found_slot, m_axis_tdata[5:0]);
            fail_count++;
          end
          if (m_axis_tdata[6] !== e.marked_stale) begin
            $error("marked_stale exp %0d got %0d", e.marked_stale, m_axis_tdata[6]);
            fail_count++;
          end
          if (m_axis_tdata[17:7] !== e.dropped_count) begin
            $error("dropped_count exp %0d got %0d", e.dropped_count, m_axis_tdata[17:7]);
            fail_count++;
          end
          if (m_axis_tdata[28:18] !== e.closed_up_count) begin
            $error("closed_up_count exp %0d got %0d", e.closed_up_count,
                   m_axis_tdata[28:18]);
            fail_count++;
          end
          if (m_axis_tdata[39:29] !== e.staled_count) begin
            $error("staled_count exp %0d got %0d", e.staled_count, m_axis_tdata[39:29]);
            fail_count++;
          end
        end
        hold_cycles = (beats_out == 120) ? 400 :
                      (burst_mode ? 0 : $urandom_range(0, 15));
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    tag_req_t r;
    hold_cycles = 0;
    req_gap = 0;
    beats_out = 0;
    fail_count = 0;
    burst_mode = 1'b0;
    for (int n = 0; n < TotalSlots; n++) clear_entry(n);

    // Directed: fill page 0 and page 1, then find and invalidate.
    pending_reqs.push_back(mk_req(OP_WRITE, 0, 0, 1, 0, 5, 32'd7, 64'hA));
    pending_reqs.push_back(mk_req(OP_WRITE, 0, 1, 1, 2, 65535, 32'hFFFF_FFFF,
                                  64'hFFFF_FFFF_FFFF_FFFF));
    pending_reqs.push_back(mk_req(OP_WRITE, 0, 2, 3, 255, 131071, 32'd0, 64'hB));
    pending_reqs.push_back(mk_req(OP_WRITE, 0, 3, 1, 1, 9, 32'd1, 64'hA));
    pending_reqs.push_back(mk_req(OP_WRITE, 1, 0, 1, 0, 1, 32'd1, 64'hC));
    pending_reqs.push_back(mk_req(OP_WRITE, 1, 1, 2, 4, 1, 32'd1, 64'hC));
    pending_reqs.push_back(mk_req(OP_WRITE, 31, 31, 1, 2, 0, 32'd0, 64'h0));
    pending_reqs.push_back(mk_req(OP_FIND, 0, 0, 0, 0, 5, 32'd7, 64'hA));
    pending_reqs.push_back(mk_req(OP_FIND, 0, 0, 0, 0, 9, 32'd2, 64'hA));
    pending_reqs.push_back(mk_req(OP_FIND, 0, 0, 0, 2, 0, 32'd0,
                                  64'hFFFF_FFFF_FFFF_FFFF));
    pending_reqs.push_back(mk_req(OP_FIND, 0, 0, 0, 0, 131071, 32'd0, 64'hB));
    pending_reqs.push_back(mk_req(OP_FIND, 0, 31, 3, 253, 65535, 32'hFFFF_FFFF,
                                  64'hFFFF_FFFF_FFFF_FFFF));
    pending_reqs.push_back(mk_req(OP_FIND, 5, 0, 0, 0, 0, 32'd0, 64'h0));
    pending_reqs.push_back(mk_req(OP_FIND, 31, 0, 0, 2, 0, 32'd0, 64'h0));
    pending_reqs.push_back(mk_req(OP_NOP, 31, 31, 3, 255, 131071, 32'hFFFF_FFFF,
                                  64'hFFFF_FFFF_FFFF_FFFF));
    pending_reqs.push_back(mk_inval(1, 64, 0, 64, 10));
    pending_reqs.push_back(mk_inval(0, 64, 0, 64, 10));
    pending_reqs.push_back(mk_inval(0, 63, 0, 2, 10));
    pending_reqs.push_back(mk_inval(255, -32768, -32768, 32767, 32767));
    pending_reqs.push_back(mk_inval(0, 32767, 32767, 32767, 32767));
    pending_reqs.push_back(mk_inval(0, -32768, -32768, -32768, -32768));
    pending_reqs.push_back(mk_inval(0, 0, 0, 1024, 512));

    // Random part.
    for (int i = 0; i < 450; i++) pending_reqs.push_back(rand_req());

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_reqs.size() == 0 && !s_axis_tvalid && expected_results.size() == 0);
    repeat (8000) @(posedge clk_i);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #100ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
